>>> hw/rtl/qwvs_pkg.sv
package qwvs_pkg;

   typedef struct packed {
      logic signed [31:0] joint_px;
      logic signed [31:0] joint_py;
      logic signed [31:0] joint_pz;
      logic signed [15:0] joint_qx;
      logic signed [15:0] joint_qy;
      logic signed [15:0] joint_qz;
      logic signed [15:0] joint_qw;
      logic signed [31:0] weight_x;
      logic signed [31:0] weight_y;
      logic signed [31:0] weight_z;
      logic        [15:0] bias;
      logic               last_weight;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] vertex_x;
      logic signed [31:0] vertex_y;
      logic signed [31:0] vertex_z;
      logic               clipped;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      A_QX, A_QY, A_QZ, A_QW, A_VX, A_VY, A_VZ,
      A_TX, A_TY, A_TZ, A_TW, A_SX, A_SY, A_SZ
   } a_sel_type;

   typedef enum logic [3:0] {
      B_QX, B_QY, B_QZ, B_QW, B_NX, B_NY, B_NZ, B_NW, B_BIAS
   } b_sel_type;

   typedef enum logic [1:0] {
      D_S, D_T, D_F, D_B
   } dest_type;

   localparam logic [1:0] LANE_X = 2'd0;
   localparam logic [1:0] LANE_Y = 2'd1;
   localparam logic [1:0] LANE_Z = 2'd2;
   localparam logic [1:0] LANE_W = 2'd3;

   typedef struct packed {
      a_sel_type  a_sel;
      b_sel_type  b_sel;
      logic       neg;
      logic       first;
      logic       last;
      dest_type   dest;
      logic [1:0] lane;
   } mac_cmd_type;

   typedef struct packed {
      logic        load;
      logic        mac_valid;
      mac_cmd_type mac;
      logic        root_step;
      logic        div_init;
      logic        div_step;
      logic        emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
      logic last;
   } dp_status_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_MAC_A, ST_ROOT, ST_DIV_INIT, ST_DIV, ST_MAC_B, ST_DRAIN, ST_EMIT
   } state_type;

   localparam int CNT_W       = 5;
   localparam int MAC_A_LAST  = 15;
   localparam int MAC_B_FIRST = 16;
   localparam int MAC_B_LAST  = 30;
   localparam int ROOT_STEPS  = 31;
   localparam int DIV_STEPS   = 25;

   function automatic mac_cmd_type mac_step(input logic [CNT_W-1:0] idx);
      mac_cmd_type c;
      c = '{A_QX, B_QX, 1'b0, 1'b0, 1'b0, D_S, LANE_X};
      unique case (idx)
         5'd0:  c = '{A_QX, B_QX, 1'b0, 1'b1, 1'b0, D_S, LANE_X};
         5'd1:  c = '{A_QY, B_QY, 1'b0, 1'b0, 1'b0, D_S, LANE_X};
         5'd2:  c = '{A_QZ, B_QZ, 1'b0, 1'b0, 1'b0, D_S, LANE_X};
         5'd3:  c = '{A_QW, B_QW, 1'b0, 1'b0, 1'b1, D_S, LANE_X};
         5'd4:  c = '{A_VX, B_QX, 1'b1, 1'b1, 1'b0, D_T, LANE_W};
         5'd5:  c = '{A_VY, B_QY, 1'b1, 1'b0, 1'b0, D_T, LANE_W};
         5'd6:  c = '{A_VZ, B_QZ, 1'b1, 1'b0, 1'b1, D_T, LANE_W};
         5'd7:  c = '{A_VX, B_QW, 1'b0, 1'b1, 1'b0, D_T, LANE_X};
         5'd8:  c = '{A_VZ, B_QY, 1'b0, 1'b0, 1'b0, D_T, LANE_X};
         5'd9:  c = '{A_VY, B_QZ, 1'b1, 1'b0, 1'b1, D_T, LANE_X};
         5'd10: c = '{A_VY, B_QW, 1'b0, 1'b1, 1'b0, D_T, LANE_Y};
         5'd11: c = '{A_VX, B_QZ, 1'b0, 1'b0, 1'b0, D_T, LANE_Y};
         5'd12: c = '{A_VZ, B_QX, 1'b1, 1'b0, 1'b1, D_T, LANE_Y};
         5'd13: c = '{A_VZ, B_QW, 1'b0, 1'b1, 1'b0, D_T, LANE_Z};
         5'd14: c = '{A_VY, B_QX, 1'b0, 1'b0, 1'b0, D_T, LANE_Z};
         5'd15: c = '{A_VX, B_QY, 1'b1, 1'b0, 1'b1, D_T, LANE_Z};
         5'd16: c = '{A_TX, B_NW, 1'b0, 1'b1, 1'b0, D_F, LANE_X};
         5'd17: c = '{A_TW, B_NX, 1'b0, 1'b0, 1'b0, D_F, LANE_X};
         5'd18: c = '{A_TY, B_NZ, 1'b0, 1'b0, 1'b0, D_F, LANE_X};
         5'd19: c = '{A_TZ, B_NY, 1'b1, 1'b0, 1'b1, D_F, LANE_X};
         5'd20: c = '{A_TY, B_NW, 1'b0, 1'b1, 1'b0, D_F, LANE_Y};
         5'd21: c = '{A_TW, B_NY, 1'b0, 1'b0, 1'b0, D_F, LANE_Y};
         5'd22: c = '{A_TZ, B_NX, 1'b0, 1'b0, 1'b0, D_F, LANE_Y};
         5'd23: c = '{A_TX, B_NZ, 1'b1, 1'b0, 1'b1, D_F, LANE_Y};
         5'd24: c = '{A_TZ, B_NW, 1'b0, 1'b1, 1'b0, D_F, LANE_Z};
         5'd25: c = '{A_TW, B_NZ, 1'b0, 1'b0, 1'b0, D_F, LANE_Z};
         5'd26: c = '{A_TX, B_NY, 1'b0, 1'b0, 1'b0, D_F, LANE_Z};
         5'd27: c = '{A_TY, B_NX, 1'b1, 1'b0, 1'b1, D_F, LANE_Z};
         5'd28: c = '{A_SX, B_BIAS, 1'b0, 1'b1, 1'b1, D_B, LANE_X};
         5'd29: c = '{A_SY, B_BIAS, 1'b0, 1'b1, 1'b1, D_B, LANE_Y};
         5'd30: c = '{A_SZ, B_BIAS, 1'b0, 1'b1, 1'b1, D_B, LANE_Z};
         default: c = '{A_QX, B_QX, 1'b0, 1'b0, 1'b0, D_S, LANE_X};
      endcase
      return c;
   endfunction

endpackage

>>> hw/rtl/quaternion_weighted_vertex_skinning.sv
// Each transaction runs the 31-step square root, the 25-step quotient lanes and 31 passes through
//    the single shared multiplier before it completes.
// Flow: a new transaction is accepted only when the previous one is done; a final weight whose
//    result slot is still held waits in its last state until the slot frees.
// Reset: synchronous, active high; clears the controller, the vertex sum accumulators and result valid.
module quaternion_weighted_vertex_skinning
   import qwvs_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   qwvs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   qwvs_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

>>> hw/rtl/qwvs_ctrl.sv
module qwvs_ctrl
   import qwvs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (req_valid) begin
               state_in = ST_MAC_A;
            end
         end
         ST_MAC_A: begin
            if (cnt_ff == CNT_W'(MAC_A_LAST)) begin
               state_in = ST_ROOT;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_ROOT: begin
            if (cnt_ff == CNT_W'(ROOT_STEPS - 1)) begin
               state_in = ST_DIV_INIT;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DIV_INIT: begin
            state_in = ST_DIV;
            cnt_in   = '0;
         end
         ST_DIV: begin
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_MAC_B;
               cnt_in   = CNT_W'(MAC_B_FIRST);
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_MAC_B: begin
            if (cnt_ff == CNT_W'(MAC_B_LAST)) begin
               state_in = ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!status.last || status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall     = (state_ff != ST_IDLE);
      cmd           = '0;
      cmd.mac       = mac_step(cnt_ff);
      cmd.load      = (state_ff == ST_IDLE) && req_valid;
      cmd.mac_valid = (state_ff == ST_MAC_A) || (state_ff == ST_MAC_B);
      cmd.root_step = (state_ff == ST_ROOT);
      cmd.div_init  = (state_ff == ST_DIV_INIT);
      cmd.div_step  = (state_ff == ST_DIV);
      cmd.emit      = (state_ff == ST_EMIT) && status.last && status.out_free;
   end

endmodule

>>> hw/rtl/qwvs_dp.sv
module qwvs_dp
   import qwvs_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data,
   input  ctrl_cmd_type    cmd,
   output dp_status_type   status
);

   req_payload_type        in_ff;
   logic signed [15:0]     q_lane [4];

   logic signed [40:0]     a_op;
   logic signed [26:0]     b_op;
   logic signed [67:0]     mul_full;
   logic signed [63:0]     prod_ff;
   mac_cmd_type            pcmd_ff;
   logic                   pvalid_ff;
   logic signed [63:0]     acc_ff, acc_in;

   logic signed [34:0]     t_ff [4];
   logic signed [38:0]     f_ff [3];
   logic signed [47:0]     sum_ff [3];
   logic signed [47:0]     sum_in [3];
   logic signed [40:0]     contrib;

   logic [60:0]            rx_ff, rr_ff, rb_ff;
   logic [60:0]            trial;
   logic                   root_ge;
   logic [30:0]            mag_m;

   logic [31:0]            rem_ff [4];
   logic [24:0]            quo_ff [4];
   logic                   sgn_ff [4];
   logic                   zero_ff;
   logic signed [25:0]     n_lane [4];
   logic [16:0]            mag [4];

   rsp_payload_type        out_ff;
   logic                   out_valid_ff;
   logic                   wb;
   logic [2:0]             hi, lo;

   assign q_lane[0] = in_ff.joint_qx;
   assign q_lane[1] = in_ff.joint_qy;
   assign q_lane[2] = in_ff.joint_qz;
   assign q_lane[3] = in_ff.joint_qw;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         in_ff <= req_data;
      end
   end

   always_comb begin
      unique case (cmd.mac.a_sel)
         A_QX:    a_op = 41'(in_ff.joint_qx);
         A_QY:    a_op = 41'(in_ff.joint_qy);
         A_QZ:    a_op = 41'(in_ff.joint_qz);
         A_QW:    a_op = 41'(in_ff.joint_qw);
         A_VX:    a_op = 41'(in_ff.weight_x);
         A_VY:    a_op = 41'(in_ff.weight_y);
         A_VZ:    a_op = 41'(in_ff.weight_z);
         A_TX:    a_op = 41'(t_ff[LANE_X]);
         A_TY:    a_op = 41'(t_ff[LANE_Y]);
         A_TZ:    a_op = 41'(t_ff[LANE_Z]);
         A_TW:    a_op = 41'(t_ff[LANE_W]);
         A_SX:    a_op = 41'(in_ff.joint_px) + 41'(f_ff[0]);
         A_SY:    a_op = 41'(in_ff.joint_py) + 41'(f_ff[1]);
         A_SZ:    a_op = 41'(in_ff.joint_pz) + 41'(f_ff[2]);
         default: a_op = '0;
      endcase
      unique case (cmd.mac.b_sel)
         B_QX:    b_op = 27'(in_ff.joint_qx);
         B_QY:    b_op = 27'(in_ff.joint_qy);
         B_QZ:    b_op = 27'(in_ff.joint_qz);
         B_QW:    b_op = 27'(in_ff.joint_qw);
         B_NX:    b_op = 27'(n_lane[LANE_X]);
         B_NY:    b_op = 27'(n_lane[LANE_Y]);
         B_NZ:    b_op = 27'(n_lane[LANE_Z]);
         B_NW:    b_op = 27'(n_lane[LANE_W]);
         B_BIAS:  b_op = $signed({11'd0, in_ff.bias});
         default: b_op = '0;
      endcase
   end

   assign mul_full = a_op * b_op;

   always_ff @(posedge clock) begin
      if (reset) begin
         pvalid_ff <= 1'b0;
      end else begin
         pvalid_ff <= cmd.mac_valid;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_full[63:0];
      pcmd_ff <= cmd.mac;
   end

   always_comb begin
      acc_in = (pcmd_ff.first ? 64'sd0 : acc_ff) + (pcmd_ff.neg ? -prod_ff : prod_ff);
   end

   assign wb      = pvalid_ff && pcmd_ff.last;
   assign contrib = acc_in[55:15];

   assign trial   = rr_ff + rb_ff;
   assign root_ge = (rx_ff >= trial);
   assign mag_m   = rr_ff[30:0];

   always_ff @(posedge clock) begin
      if (pvalid_ff) begin
         acc_ff <= acc_in;
      end
      if (wb && pcmd_ff.dest == D_T) begin
         t_ff[pcmd_ff.lane] <= acc_in[48:14];
      end
      if (wb && pcmd_ff.dest == D_F && pcmd_ff.lane != LANE_W) begin
         f_ff[pcmd_ff.lane] <= acc_in[62:24];
      end
      if (wb && pcmd_ff.dest == D_S) begin
         rx_ff <= 61'(acc_in[32:0]) << 28;
         rr_ff <= '0;
         rb_ff <= 61'(1) << 60;
      end else if (cmd.root_step) begin
         rx_ff <= root_ge ? rx_ff - trial : rx_ff;
         rr_ff <= root_ge ? (rr_ff >> 1) + rb_ff : rr_ff >> 1;
         rb_ff <= rb_ff >> 2;
      end
      if (cmd.div_init) begin
         zero_ff <= (mag_m == '0);
      end
   end

   for (genvar i = 0; i < 4; i++) begin : g_div
      logic signed [16:0] qe;
      logic [31:0]        rem2;
      logic               ge;
      assign qe     = 17'(q_lane[i]);
      assign mag[i] = qe[16] ? 17'(-qe) : 17'(qe);
      assign rem2   = rem_ff[i] << 1;
      assign ge     = (rem2 >= 32'(mag_m));
      assign n_lane[i] = zero_ff ? 26'sd0 :
                         sgn_ff[i] ? -$signed(26'(quo_ff[i])) : $signed(26'(quo_ff[i]));
      always_ff @(posedge clock) begin
         if (cmd.div_init) begin
            rem_ff[i] <= 32'(mag[i]) << 13;
            quo_ff[i] <= '0;
            sgn_ff[i] <= (i == int'(LANE_W)) ? q_lane[i][15] : !q_lane[i][15];
         end else if (cmd.div_step) begin
            rem_ff[i] <= ge ? rem2 - 32'(mag_m) : rem2;
            quo_ff[i] <= {quo_ff[i][23:0], ge};
         end
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_sum
      logic signed [48:0] s;
      assign s = 49'(sum_ff[i]) + 49'(contrib);
      always_comb begin
         priority if (s > 49'sh0_7FFF_FFFF_FFFF) begin
            sum_in[i] = 48'sh7FFF_FFFF_FFFF;
         end else if (s < -49'sh0_8000_0000_0000) begin
            sum_in[i] = 48'sh8000_0000_0000;
         end else begin
            sum_in[i] = s[47:0];
         end
      end
      assign hi[i] = sum_ff[i] > 48'sh0000_7FFF_FFFF;
      assign lo[i] = sum_ff[i] < -48'sh0000_8000_0000;
      always_ff @(posedge clock) begin
         if (reset) begin
            sum_ff[i] <= '0;
         end else if (cmd.emit) begin
            sum_ff[i] <= '0;
         end else if (wb && pcmd_ff.dest == D_B && pcmd_ff.lane == 2'(i)) begin
            sum_ff[i] <= sum_in[i];
         end
      end
   end

   function automatic logic signed [31:0] clamp32(input logic signed [47:0] v,
                                                  input logic h, input logic l);
      logic signed [31:0] r;
      r = v[31:0];
      if (h) begin
         r = 32'sh7FFF_FFFF;
      end else if (l) begin
         r = 32'sh8000_0000;
      end
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= cmd.emit || (out_valid_ff && rsp_stall);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_ff.vertex_x <= clamp32(sum_ff[0], hi[0], lo[0]);
         out_ff.vertex_y <= clamp32(sum_ff[1], hi[1], lo[1]);
         out_ff.vertex_z <= clamp32(sum_ff[2], hi[2], lo[2]);
         out_ff.clipped  <= |(hi | lo);
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_data        = out_ff;
   assign status.out_free = !out_valid_ff || !rsp_stall;
   assign status.last     = in_ff.last_weight;

endmodule
